// ===== hdl/mbmf_pkg.sv =====
// shared constants, types and state encoding of the block median filter
package mbmf_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int NUM_FIELDS   = 4;
  localparam int DEF_WINDOW   = 8;
  localparam int DEF_CHANNELS = 4;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic wr_en;
    logic scan_step;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fill_last;
    logic scan_last;
  } dp_status_t;

endpackage

// ===== hdl/mbmf_if.sv =====
// request channel interfaces for samples in and medians out
interface mbmf_sample_if;
  logic                    valid;
  logic                    ready;
  logic [mbmf_pkg::SAMPLE_W-1:0] sample_ch0;
  logic [mbmf_pkg::SAMPLE_W-1:0] sample_ch1;
  logic [mbmf_pkg::SAMPLE_W-1:0] sample_ch2;
  logic [mbmf_pkg::SAMPLE_W-1:0] sample_ch3;

  modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  input ready);
  modport sink   (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                  output ready);
endinterface

interface mbmf_median_if;
  logic                    valid;
  logic                    ready;
  logic [mbmf_pkg::SAMPLE_W-1:0] median_ch0;
  logic [mbmf_pkg::SAMPLE_W-1:0] median_ch1;
  logic [mbmf_pkg::SAMPLE_W-1:0] median_ch2;
  logic [mbmf_pkg::SAMPLE_W-1:0] median_ch3;

  modport source (output valid, median_ch0, median_ch1, median_ch2, median_ch3,
                  input ready);
  modport sink   (input valid, median_ch0, median_ch1, median_ch2, median_ch3,
                  output ready);
endinterface

// ===== hdl/mbmf_ctrl.sv =====
// controller state machine of the block median filter
module mbmf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mbmf_pkg::dp_cmd_t    cmd_o,
  input  mbmf_pkg::dp_status_t status_i
);
  import mbmf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && status_i.fill_last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o.scan_step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_OUT: begin
        // filling may go on, but a completing sample waits for the result to leave
        out_valid_o = 1'b1;
        in_ready_o  = !status_i.fill_last;
      end
      default: begin
      end
    endcase
    cmd_o.wr_en = in_fire;
  end

  // a completing sample never lands while a result is pending
  a_no_complete_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> !(in_fire && status_i.fill_last))
    else $error("window completed while result pending");

  // the last scan step moves the controller to the drain state
  a_scan_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && status_i.scan_last) |=> (state_q == ST_DRAIN))
    else $error("scan did not end in drain");

  // a result appears right after the drain cycle
  a_drain_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> out_valid_o)
    else $error("result not presented after drain");

  // completing a window starts a scan
  a_fill_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_fire && status_i.fill_last) |=> (state_q == ST_SCAN))
    else $error("scan not started after last sample");

endmodule

// ===== hdl/mbmf_datapath.sv =====
// window memories, rank counting and median registers
module mbmf_datapath #(
  parameter int WINDOW   = mbmf_pkg::DEF_WINDOW,
  parameter int CHANNELS = mbmf_pkg::DEF_CHANNELS
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  mbmf_pkg::dp_cmd_t                                cmd_i,
  output mbmf_pkg::dp_status_t                             status_o,
  input  logic [mbmf_pkg::NUM_FIELDS-1:0][mbmf_pkg::SAMPLE_W-1:0] samples_i,
  output logic [mbmf_pkg::NUM_FIELDS-1:0][mbmf_pkg::SAMPLE_W-1:0] medians_o
);
  import mbmf_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] MID_RANK = CNT_W'(WINDOW / 2);

  logic [IDX_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] cand_q, cand_d;
  logic [IDX_W-1:0] peer_q, peer_d;
  logic             fill_last, peer_last;

  // read pipeline stage flags
  logic             rd_v_q;
  logic             rd_first_q;
  logic             rd_last_q;
  logic [IDX_W-1:0] rd_cand_q;
  logic [IDX_W-1:0] rd_peer_q;

  assign fill_last          = (fill_q == LAST_IDX);
  assign peer_last          = (peer_q == LAST_IDX);
  assign status_o.fill_last = fill_last;
  assign status_o.scan_last = cmd_i.scan_step && peer_last && (cand_q == LAST_IDX);

  // fill position and scan index pair
  always_comb begin
    fill_d = fill_q;
    cand_d = cand_q;
    peer_d = peer_q;
    if (cmd_i.wr_en) begin
      fill_d = fill_last ? '0 : fill_q + 1'b1;
    end
    if (cmd_i.scan_step) begin
      if (peer_last) begin
        peer_d = '0;
        cand_d = (cand_q == LAST_IDX) ? '0 : cand_q + 1'b1;
      end else begin
        peer_d = peer_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cand_q <= '0;
      peer_q <= '0;
      rd_v_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      cand_q <= cand_d;
      peer_q <= peer_d;
      rd_v_q <= cmd_i.scan_step;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_first_q <= (peer_q == '0);
    rd_last_q  <= peer_last;
    rd_cand_q  <= cand_q;
    rd_peer_q  <= peer_q;
  end

  // one window memory and rank counter per active channel
  for (genvar ch = 0; ch < NUM_FIELDS; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_active
      sample_t          mem [WINDOW];
      sample_t          cand_val_q;
      sample_t          peer_val_q;
      logic [CNT_W-1:0] rank_q, rank_d;
      sample_t          median_q;
      logic             below;

      // window write and two registered reads
      always_ff @(posedge clk_i) begin
        if (cmd_i.wr_en) begin
          mem[fill_q] <= samples_i[ch];
        end
        cand_val_q <= mem[cand_q];
        peer_val_q <= mem[peer_q];
      end

      // peer sorts ahead of candidate, ties broken by position
      assign below = (peer_val_q < cand_val_q) ||
                     ((peer_val_q == cand_val_q) && (rd_peer_q < rd_cand_q));

      always_comb begin
        rank_d = (rd_first_q ? '0 : rank_q) + CNT_W'(below);
      end

      // rank accumulation and median capture
      always_ff @(posedge clk_i) begin
        if (rd_v_q) begin
          rank_q <= rank_d;
          if (rd_last_q && (rank_d == MID_RANK)) begin
            median_q <= cand_val_q;
          end
        end
      end

      assign medians_o[ch] = median_q;
    end else begin : g_idle
      assign medians_o[ch] = '0;
    end
  end

endmodule

// ===== hdl/multichannel_block_median_filter_core.sv =====
// top level of the multichannel block median decimation filter
//
// Usage: samp_i takes one request per conversion set, four 12-bit samples,
// one per channel. Each set is written into its channel's window at the
// current fill position. The set that fills the last position triggers a
// scan, and med_o then presents one request with the sorted element at index
// WINDOW/2 of every active channel; inactive channels read as zero.
// The rank-counting scan visits every candidate and peer pair once, all
// channels in parallel, through the two read ports of each window memory.
// Samples are taken at one sample per cycle while filling, but none during
// the scan and drain.
// Reset clears the fill position and controller; window contents are
// undefined until filled, and no clearing pass is needed.
// While the receiver stalls the result is held, and further samples of the
// next window are still taken, except the one that would complete it.
module multichannel_block_median_filter_core #(
  parameter int WINDOW   = mbmf_pkg::DEF_WINDOW,
  parameter int CHANNELS = mbmf_pkg::DEF_CHANNELS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbmf_sample_if.sink   samp_i,
  mbmf_median_if.source med_o
);
  import mbmf_pkg::*;

  dp_cmd_t                                  cmd;
  dp_status_t                               status;
  logic [NUM_FIELDS-1:0][SAMPLE_W-1:0]      samples;
  logic [NUM_FIELDS-1:0][SAMPLE_W-1:0]      medians;

  // payload packing
  assign samples[0] = samp_i.sample_ch0;
  assign samples[1] = samp_i.sample_ch1;
  assign samples[2] = samp_i.sample_ch2;
  assign samples[3] = samp_i.sample_ch3;

  assign med_o.median_ch0 = medians[0];
  assign med_o.median_ch1 = medians[1];
  assign med_o.median_ch2 = medians[2];
  assign med_o.median_ch3 = medians[3];

  // controller
  mbmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (samp_i.valid),
    .in_ready_o  (samp_i.ready),
    .out_valid_o (med_o.valid),
    .out_ready_i (med_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // datapath
  mbmf_datapath #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .samples_i (samples),
    .medians_o (medians)
  );

endmodule

// ===== tb/multichannel_block_median_filter_core_test.sv =====
// self-checking testbench of the multichannel block median decimation filter
module multichannel_block_median_filter_core_test;
  import mbmf_pkg::*;

  localparam int WIN       = DEF_WINDOW;
  localparam int CHN       = DEF_CHANNELS;
  localparam int MAX_WAIT  = 8;
  localparam int LIMIT     = 400000;
  localparam int DRAIN_CYC = WIN * WIN + 2 + 16;

  typedef logic [NUM_FIELDS-1:0][SAMPLE_W-1:0] chan_vec_t;
  typedef sample_t win_t [WIN];

  // kinds of window content for the random part
  typedef enum int {
    FILL_UNIFORM,
    FILL_EXTREME,
    FILL_CLUSTER,
    FILL_RAMP_UP,
    FILL_RAMP_DOWN
  } fill_kind_e;

  logic clk_i;
  logic rst_ni;

  mbmf_sample_if samp ();
  mbmf_median_if med ();

  multichannel_block_median_filter_core #(
    .WINDOW   (WIN),
    .CHANNELS (CHN)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (samp),
    .med_o  (med)
  );

  // filter state mirror and expected medians
  win_t        chan_win [CHN];
  int          fill_pos;
  chan_vec_t   pending_medians [$];
  int          mismatch_count;
  int          cycle_count;
  bit          gaps_on;
  bit          stalls_on;

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic int draw_wait(input bit on);
    return on ? int'($urandom_range(0, MAX_WAIT)) : 0;
  endfunction

  // sorted element at the middle index of one window
  function automatic sample_t window_median(input win_t w);
    win_t    s;
    sample_t key;
    int      j;
    s = w;
    for (int i = 1; i < WIN; i++) begin
      key = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > key) begin
        s[j+1] = s[j];
        j--;
      end
      s[j+1] = key;
    end
    return s[WIN/2];
  endfunction

  // store one accepted conversion set, queue the medians when a window fills
  task automatic store_set(input chan_vec_t set);
    chan_vec_t meds;
    for (int ch = 0; ch < CHN; ch++) chan_win[ch][fill_pos] = set[ch];
    if (fill_pos < WIN - 1) begin
      fill_pos++;
    end else begin
      fill_pos = 0;
      meds = '0;
      for (int ch = 0; ch < CHN; ch++) meds[ch] = window_median(chan_win[ch]);
      pending_medians.push_back(meds);
    end
  endtask

  // send one conversion set request
  task automatic send_set(input chan_vec_t set);
    int gap;
    gap = draw_wait(gaps_on);
    @(negedge clk_i);
    if (gap > 0) begin
      samp.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    samp.valid      <= 1'b1;
    samp.sample_ch0 <= set[0];
    samp.sample_ch1 <= set[1];
    samp.sample_ch2 <= set[2];
    samp.sample_ch3 <= set[3];
    do @(posedge clk_i); while (!samp.ready);
    store_set(set);
  endtask

  // median receiver, stalls after a result shows up
  initial begin : median_sink
    int stall;
    med.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(stalls_on);
      @(negedge clk_i);
      med.ready <= (stall == 0);
      if (stall > 0) begin
        do @(posedge clk_i); while (!med.valid);
        repeat (stall) @(negedge clk_i);
        med.ready <= 1'b1;
      end
      do @(posedge clk_i); while (!(med.valid && med.ready));
    end
  end

  // compare each accepted median set with the oldest expectation
  always @(posedge clk_i) begin : check_medians
    chan_vec_t got;
    chan_vec_t want;
    if (rst_ni && med.valid && med.ready) begin
      got = {med.median_ch3, med.median_ch2, med.median_ch1, med.median_ch0};
      if (pending_medians.size() == 0) begin
        report_mismatch($sformatf("unexpected median set %h", got));
      end else begin
        want = pending_medians.pop_front();
        for (int ch = 0; ch < NUM_FIELDS; ch++) begin
          if (got[ch] !== want[ch])
            report_mismatch($sformatf("median_ch%0d got %h want %h", ch, got[ch], want[ch]));
        end
      end
    end
  end

  function automatic sample_t pick_sample(input fill_kind_e kind, input int idx,
                                          input sample_t centre);
    sample_t v;
    case (kind)
      FILL_EXTREME: begin
        v = $urandom_range(0, 1) ? '1 : '0;
      end
      FILL_CLUSTER: begin
        v = centre ^ sample_t'($urandom_range(0, 3));
      end
      FILL_RAMP_UP: begin
        v = centre + sample_t'(idx * 37);
      end
      FILL_RAMP_DOWN: begin
        v = centre - sample_t'(idx * 37);
      end
      default: begin
        v = sample_t'($urandom());
      end
    endcase
    return v;
  endfunction

  // one window of random content, the kind drawn per channel
  task automatic send_random_window();
    fill_kind_e kind   [NUM_FIELDS];
    sample_t    centre [NUM_FIELDS];
    chan_vec_t  set;
    for (int ch = 0; ch < NUM_FIELDS; ch++) begin
      kind[ch]   = fill_kind_e'($urandom_range(0, 4));
      centre[ch] = sample_t'($urandom());
    end
    for (int i = 0; i < WIN; i++) begin
      for (int ch = 0; ch < NUM_FIELDS; ch++) set[ch] = pick_sample(kind[ch], i, centre[ch]);
      send_set(set);
    end
  endtask

  // extremes: flat zero, flat full scale, rising and falling ramps
  task automatic test_extremes();
    chan_vec_t set;
    for (int i = 0; i < WIN; i++) begin
      set[0] = '0;
      set[1] = '1;
      set[2] = sample_t'(i * 585);
      set[3] = sample_t'(4095 - i * 585);
      send_set(set);
    end
  endtask

  // duplicates and upper median of a split window, checkerboard bit patterns
  task automatic test_duplicates();
    chan_vec_t set;
    for (int i = 0; i < WIN; i++) begin
      set[0] = (i % 2 == 0) ? '0 : '1;
      set[1] = (i < WIN / 2) ? 12'haaa : 12'h555;
      set[2] = (i == 3) ? 12'hfff : 12'h800;
      set[3] = (i < 3) ? 12'h001 : 12'h7ff;
      send_set(set);
    end
    // all equal except one outlier in channels 0 and 1; channels 2 and 3 flat
    for (int i = 0; i < WIN; i++) begin
      set[0] = (i == 0) ? 12'hfff : 12'h123;
      set[1] = (i == WIN - 1) ? 12'h000 : 12'hedc;
      set[2] = 12'h555;
      set[3] = 12'haaa;
      send_set(set);
    end
  endtask

  // random windows with idle and stall phases switched every few windows
  task automatic test_random_windows(input int windows);
    for (int w = 0; w < windows; w++) begin
      if (w % 6 == 0) begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_random_window();
    end
    // trailing partial window, completed by the sets of the next test
    for (int i = 0; i < 5; i++) send_set(chan_vec_t'({$urandom(), $urandom()}));
  endtask

  // back to back requests with the receiver always ready
  task automatic test_back_to_back(input int windows);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int w = 0; w < windows; w++) send_random_window();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    samp.valid      = 1'b0;
    samp.sample_ch0 = '0;
    samp.sample_ch1 = '0;
    samp.sample_ch2 = '0;
    samp.sample_ch3 = '0;
    fill_pos        = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_duplicates();
    test_back_to_back(3);
    test_random_windows(185);
    test_back_to_back(4);

    @(negedge clk_i);
    samp.valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mbmf_pkg.sv
hdl/mbmf_if.sv
hdl/mbmf_ctrl.sv
hdl/mbmf_datapath.sv
hdl/multichannel_block_median_filter_core.sv
tb/multichannel_block_median_filter_core_test.sv
